FILE: rtl/cmtf_pkg.sv
`timescale 1ns / 1ps
// cmtf_pkg: shared types, widths and codes of the cube map texel fetch unit
// no dependencies; used by the top level and the divider pipeline

package cmtf_pkg;

	// default largest face side
	localparam int MAX_SIDE_DEF = 64;
	localparam int NUM_FACES    = 6;

	// field widths
	localparam int SIDE_W    = 7;
	localparam int DIR_W     = 16;
	localparam int FACE_W    = 3;
	localparam int TIDX_W    = 12;
	localparam int TEXEL_W   = 32;
	localparam int CHAN_W    = 8;
	localparam int CFG_IDX_W = 1;

	// divider datapath: numerator holds (minor+major)*(side-1), denominator 2*major
	localparam int NUM_W = DIR_W + SIDE_W + 1;
	localparam int DEN_W = DIR_W + 1;
	// texel offset within a face, x + y*width with both sides below 128
	localparam int IDX_W = 2 * SIDE_W;

	// item operations
	typedef enum logic {
		OP_STORE  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FACE_WIDTH  = 1'b0,
		CFG_FACE_HEIGHT = 1'b1
	} cfg_reg_t;

	// face codes
	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

	// opaque gray returned when no axis is strictly largest
	localparam logic [CHAN_W-1:0] GRAY_LEVEL   = 8'd128;
	localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'd255;

	typedef struct packed {
		op_t                      operation;
		logic [FACE_W-1:0]        face;
		logic [TIDX_W-1:0]        texel_index;
		logic [TEXEL_W-1:0]       texel_value;
		logic signed [DIR_W-1:0]  dir_x;
		logic signed [DIR_W-1:0]  dir_y;
		logic signed [DIR_W-1:0]  dir_z;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
		logic              tie_seen;
		logic [FACE_W-1:0] hit_face;
	} out_item_t;

endpackage

FILE: rtl/cmtf_ram.sv
`timescale 1ns / 1ps
// cmtf_ram: generic simple dual-port memory, one write and one registered read
// no dependencies

module cmtf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/cmtf_div.sv
`timescale 1ns / 1ps
// cmtf_div: pipelined restoring divider, two numerators over one denominator,
// one quotient bit per stage, side data carried along; uses cmtf_pkg widths

module cmtf_div #(
	parameter int QW    = 6,
	parameter int TAG_W = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [cmtf_pkg::NUM_W-1:0] num_a,
	input  logic [cmtf_pkg::NUM_W-1:0] num_b,
	input  logic [cmtf_pkg::DEN_W-1:0] den,
	input  logic [TAG_W-1:0]           tag_in,
	output logic                       out_valid,
	output logic [QW-1:0]              quo_a,
	output logic [QW-1:0]              quo_b,
	output logic [TAG_W-1:0]           tag_out
);

	// chain entry 0 is the input, entry j+1 is the register of stage j
	logic                       v_c    [QW+1];
	logic [cmtf_pkg::NUM_W-1:0] rema_c [QW+1];
	logic [cmtf_pkg::NUM_W-1:0] remb_c [QW+1];
	logic [cmtf_pkg::DEN_W-1:0] den_c  [QW+1];
	logic [QW-1:0]              qa_c   [QW+1];
	logic [QW-1:0]              qb_c   [QW+1];
	logic [TAG_W-1:0]           tag_c  [QW+1];

	assign v_c[0]    = in_valid;
	assign rema_c[0] = num_a;
	assign remb_c[0] = num_b;
	assign den_c[0]  = den;
	assign qa_c[0]   = '0;
	assign qb_c[0]   = '0;
	assign tag_c[0]  = tag_in;

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int B = QW - 1 - j;

		logic [cmtf_pkg::NUM_W-1:0] trial;
		logic [cmtf_pkg::NUM_W-1:0] rema_n;
		logic [cmtf_pkg::NUM_W-1:0] remb_n;
		logic [QW-1:0]              qa_n;
		logic [QW-1:0]              qb_n;
		logic                       v_q;
		logic [cmtf_pkg::NUM_W-1:0] rema_q;
		logic [cmtf_pkg::NUM_W-1:0] remb_q;
		logic [cmtf_pkg::DEN_W-1:0] den_q;
		logic [QW-1:0]              qa_q;
		logic [QW-1:0]              qb_q;
		logic [TAG_W-1:0]           tag_q;

		// compare and subtract the shifted denominator for quotient bit B
		always_comb begin
			trial  = cmtf_pkg::NUM_W'(den_c[j]) << B;
			rema_n = rema_c[j];
			remb_n = remb_c[j];
			qa_n   = qa_c[j];
			qb_n   = qb_c[j];
			if (rema_c[j] >= trial) begin
				rema_n = rema_c[j] - trial;
				qa_n   = qa_c[j] | (QW'(1) << B);
			end
			if (remb_c[j] >= trial) begin
				remb_n = remb_c[j] - trial;
				qb_n   = qb_c[j] | (QW'(1) << B);
			end
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (en) begin
				v_q <= v_c[j];
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (en) begin
				rema_q <= rema_n;
				remb_q <= remb_n;
				den_q  <= den_c[j];
				qa_q   <= qa_n;
				qb_q   <= qb_n;
				tag_q  <= tag_c[j];
			end
		end

		assign v_c[j+1]    = v_q;
		assign rema_c[j+1] = rema_q;
		assign remb_c[j+1] = remb_q;
		assign den_c[j+1]  = den_q;
		assign qa_c[j+1]   = qa_q;
		assign qb_c[j+1]   = qb_q;
		assign tag_c[j+1]  = tag_q;
	end

	assign out_valid = v_c[QW];
	assign quo_a     = qa_c[QW];
	assign quo_b     = qb_c[QW];
	assign tag_out   = tag_c[QW];

endmodule

FILE: rtl/cube_map_direction_texel_fetch_unit.sv
`timescale 1ns / 1ps
// cube_map_direction_texel_fetch_unit: six-face texel memory with direction lookup
// pipeline: s1, s2, s3, divider, s4, read and s5, output; QW = min(clog2(MAX_SIDE), 7)
// throughput: one item per cycle while in_stall is low, set by the divider and memory ports
// reset: pipeline and output empty, face_width and face_height at 64 (capped at MAX_SIDE),
// texel memory not cleared: a texel reads undefined until stored
// uses cmtf_pkg, cmtf_div, cmtf_ram

module cube_map_direction_texel_fetch_unit #(
	parameter int MAX_SIDE = cmtf_pkg::MAX_SIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cmtf_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cmtf_pkg::out_item_t            out_data,
	input  logic                           cfg_write,
	input  logic [cmtf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cmtf_pkg::SIDE_W-1:0]    cfg_data
);

	localparam int FACE_TEXELS = MAX_SIDE * MAX_SIDE;
	localparam int DEPTH       = cmtf_pkg::NUM_FACES * FACE_TEXELS;
	localparam int AW          = $clog2(DEPTH);
	localparam int QW_FULL     = $clog2(MAX_SIDE);
	localparam int QW          = (QW_FULL < cmtf_pkg::SIDE_W) ? QW_FULL : cmtf_pkg::SIDE_W;
	localparam int RESET_SIDE  = (MAX_SIDE < 64) ? MAX_SIDE : 64;
	localparam int TAG_W       = 3 + cmtf_pkg::FACE_W + AW + cmtf_pkg::TEXEL_W;

	localparam int SW = cmtf_pkg::SIDE_W;
	localparam int DW = cmtf_pkg::DIR_W;
	localparam int FW = cmtf_pkg::FACE_W;
	localparam int TW = cmtf_pkg::TEXEL_W;

	// first entry of a face in the texel memory
	function automatic logic [AW-1:0] face_base(input logic [FW-1:0] f);
		face_base = AW'(32'(f) * FACE_TEXELS);
	endfunction

	// zero reads as one, larger than MAX_SIDE saturates
	function automatic logic [SW-1:0] clamp_side(input logic [SW-1:0] v);
		logic [SW-1:0] r;
		r = v;
		if (v == '0) begin
			r = SW'(1);
		end else if (32'(v) > MAX_SIDE) begin
			r = SW'(MAX_SIDE);
		end
		return r;
	endfunction

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] d);
		mag = d[DW-1] ? (~d + DW'(1)) : d;
	endfunction

	// ------------------------------------------------------------------
	// configuration registers
	logic [SW-1:0] width_q;
	logic [SW-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SW'(RESET_SIDE);
			height_q <= SW'(RESET_SIDE);
		end else if (cfg_write) begin
			unique case (cmtf_pkg::cfg_reg_t'(cfg_index))
				cmtf_pkg::CFG_FACE_WIDTH:  width_q  <= clamp_side(cfg_data);
				cmtf_pkg::CFG_FACE_HEIGHT: height_q <= clamp_side(cfg_data);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// flow control: the whole pipeline moves unless the skid slot is full
	logic adv;
	logic sk_valid_q;

	assign adv      = !sk_valid_q;
	assign in_stall = sk_valid_q;

	// ------------------------------------------------------------------
	// s1: input register
	logic               v_s1;
	cmtf_pkg::in_item_t in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= in_data;
		end
	end

	// ------------------------------------------------------------------
	// major axis selection, offsets into [0, 2*major), store address check
	logic [DW-1:0] ax, ay, az;
	logic [DW-1:0] cls_major;
	logic [DW-1:0] cls_u, cls_v;
	logic [FW-1:0] cls_face;
	logic          cls_tie;
	logic [DW:0]   nu_full, nv_full;
	logic          st_ok;
	logic [AW-1:0] st_addr;

	always_comb begin
		ax        = mag(in_s1.dir_x);
		ay        = mag(in_s1.dir_y);
		az        = mag(in_s1.dir_z);
		cls_tie   = 1'b0;
		cls_major = ax;
		cls_u     = in_s1.dir_z;
		cls_v     = in_s1.dir_y;
		cls_face  = cmtf_pkg::FACE_POS_X;
		priority if (ax > ay && ax > az) begin
			cls_major = ax;
			cls_u     = in_s1.dir_z;
			cls_v     = in_s1.dir_y;
			cls_face  = in_s1.dir_x[DW-1] ? cmtf_pkg::FACE_NEG_X : cmtf_pkg::FACE_POS_X;
		end else if (ay > ax && ay > az) begin
			cls_major = ay;
			cls_u     = in_s1.dir_x;
			cls_v     = in_s1.dir_z;
			cls_face  = in_s1.dir_y[DW-1] ? cmtf_pkg::FACE_NEG_Y : cmtf_pkg::FACE_POS_Y;
		end else if (az > ax && az > ay) begin
			cls_major = az;
			cls_u     = in_s1.dir_x;
			cls_v     = in_s1.dir_y;
			cls_face  = in_s1.dir_z[DW-1] ? cmtf_pkg::FACE_NEG_Z : cmtf_pkg::FACE_POS_Z;
		end else begin
			cls_tie = 1'b1;
		end
		nu_full = {cls_u[DW-1], cls_u} + {1'b0, cls_major};
		nv_full = {cls_v[DW-1], cls_v} + {1'b0, cls_major};
		st_ok   = (32'(in_s1.face) < cmtf_pkg::NUM_FACES)
			&& (32'(in_s1.texel_index) < FACE_TEXELS);
		st_addr = face_base(in_s1.face) + AW'(in_s1.texel_index);
	end

	// s2: classified item
	logic          v_s2;
	logic          look_s2;
	logic          tie_s2;
	logic [FW-1:0] face_s2;
	logic [DW-1:0] major_s2;
	logic [DW-1:0] nu_s2, nv_s2;
	logic          stok_s2;
	logic [AW-1:0] stad_s2;
	logic [TW-1:0] stdat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			look_s2  <= (in_s1.operation == cmtf_pkg::OP_LOOKUP);
			tie_s2   <= cls_tie;
			face_s2  <= cls_face;
			major_s2 <= cls_major;
			nu_s2    <= nu_full[DW-1:0];
			nv_s2    <= nv_full[DW-1:0];
			stok_s2  <= st_ok;
			stad_s2  <= st_addr;
			stdat_s2 <= in_s1.texel_value;
		end
	end

	// ------------------------------------------------------------------
	// s3: scale offsets by side-1, form the denominator 2*major
	logic [SW-1:0] wm1, hm1;

	assign wm1 = width_q - SW'(1);
	assign hm1 = height_q - SW'(1);

	logic                       v_s3;
	logic [cmtf_pkg::NUM_W-1:0] numa_s3, numb_s3;
	logic [cmtf_pkg::DEN_W-1:0] den_s3;
	logic [TAG_W-1:0]           tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			numa_s3 <= cmtf_pkg::NUM_W'(nu_s2) * cmtf_pkg::NUM_W'(wm1);
			numb_s3 <= cmtf_pkg::NUM_W'(nv_s2) * cmtf_pkg::NUM_W'(hm1);
			den_s3  <= {major_s2, 1'b0};
			tag_s3  <= {look_s2, tie_s2, face_s2, stok_s2, stad_s2, stdat_s2};
		end
	end

	// ------------------------------------------------------------------
	// texel coordinates: px, py
	logic             dv_valid;
	logic [QW-1:0]    px, py;
	logic [TAG_W-1:0] dv_tag;

	cmtf_div #(
		.QW    (QW),
		.TAG_W (TAG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.num_a     (numa_s3),
		.num_b     (numb_s3),
		.den       (den_s3),
		.tag_in    (tag_s3),
		.out_valid (dv_valid),
		.quo_a     (px),
		.quo_b     (py),
		.tag_out   (dv_tag)
	);

	logic          dv_look, dv_tie, dv_stok;
	logic [FW-1:0] dv_face;
	logic [AW-1:0] dv_stad;
	logic [TW-1:0] dv_stdat;

	assign {dv_look, dv_tie, dv_face, dv_stok, dv_stad, dv_stdat} = dv_tag;

	// ------------------------------------------------------------------
	// s4: texel offset within the face
	logic                       v_s4;
	logic [cmtf_pkg::IDX_W-1:0] idx_s4;
	logic                       look_s4, tie_s4, stok_s4;
	logic [FW-1:0]              face_s4;
	logic [AW-1:0]              stad_s4;
	logic [TW-1:0]              stdat_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s4   <= cmtf_pkg::IDX_W'(px)
				+ cmtf_pkg::IDX_W'(py) * cmtf_pkg::IDX_W'(width_q);
			look_s4  <= dv_look;
			tie_s4   <= dv_tie;
			face_s4  <= dv_face;
			stok_s4  <= dv_stok;
			stad_s4  <= dv_stad;
			stdat_s4 <= dv_stdat;
		end
	end

	// memory access: stores write and lookups read at the same stage, so order holds
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [TW-1:0] ram_rdata;

	assign ram_we    = adv && v_s4 && !look_s4 && stok_s4;
	assign ram_raddr = face_base(face_s4) + AW'(idx_s4);

	cmtf_ram #(
		.WIDTH (TW),
		.DEPTH (DEPTH)
	) u_texels (
		.clk   (clk),
		.we    (ram_we),
		.waddr (stad_s4),
		.wdata (stdat_s4),
		.re    (adv),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// s5: tag alongside the read data
	logic          v_s5;
	logic          look_s5, tie_s5;
	logic [FW-1:0] face_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			look_s5 <= look_s4;
			tie_s5  <= tie_s4;
			face_s5 <= face_s4;
		end
	end

	// result beat: split the texel or return gray on a tie
	cmtf_pkg::out_item_t res;
	logic                res_valid;

	assign res_valid = v_s5 && look_s5;

	always_comb begin
		if (tie_s5) begin
			res.red      = cmtf_pkg::GRAY_LEVEL;
			res.green    = cmtf_pkg::GRAY_LEVEL;
			res.blue     = cmtf_pkg::GRAY_LEVEL;
			res.alpha    = cmtf_pkg::OPAQUE_ALPHA;
			res.tie_seen = 1'b1;
			res.hit_face = cmtf_pkg::FACE_POS_X;
		end else begin
			res.red      = ram_rdata[7:0];
			res.green    = ram_rdata[15:8];
			res.blue     = ram_rdata[23:16];
			res.alpha    = ram_rdata[31:24];
			res.tie_seen = 1'b0;
			res.hit_face = face_s5;
		end
	end

	// ------------------------------------------------------------------
	// output register with a skid slot behind it
	logic                out_valid_q;
	cmtf_pkg::out_item_t out_q;
	cmtf_pkg::out_item_t sk_q;
	logic                pop;
	logic                out_free;

	assign pop      = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (sk_valid_q) begin
			if (pop) begin
				sk_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				sk_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (pop) begin
				out_q <= sk_q;
			end
		end else if (res_valid) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				sk_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for the cube map texel fetch unit, stores then direction lookups
// depends on cmtf_pkg and cube_map_direction_texel_fetch_unit

module testbench;

	localparam int FACE_TEXELS     = cmtf_pkg::MAX_SIDE_DEF * cmtf_pkg::MAX_SIDE_DEF;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int SETTLE_CYCLES   = 24;
	localparam int PHASE_ITEMS     = 110;
	localparam int NUM_PHASES      = 8;
	localparam int HOLD_OFF_CYCLES = 300;

	localparam int SW = cmtf_pkg::SIDE_W;
	localparam int DW = cmtf_pkg::DIR_W;
	localparam int FW = cmtf_pkg::FACE_W;

	// face codes that name no face: stores to them are dropped
	localparam logic [FW-1:0] FACE_SPARE_LO = 3'd6;
	localparam logic [FW-1:0] FACE_SPARE_HI = 3'd7;

	// face size settings per phase, the last phase picks its own at random
	localparam logic [SW-1:0] PHASE_W [NUM_PHASES-1] =
		'{7'd1, 7'd0, 7'd127, 7'd64, 7'd2, 7'd33, 7'd64};
	localparam logic [SW-1:0] PHASE_H [NUM_PHASES-1] =
		'{7'd1, 7'd127, 7'd0, 7'd1, 7'd5, 7'd17, 7'd64};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	cmtf_pkg::in_item_t             in_data;
	logic                           out_valid;
	logic                           out_stall;
	cmtf_pkg::out_item_t            out_data;
	logic                           cfg_write;
	logic [cmtf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [SW-1:0]                  cfg_data;

	int cycle_count = 0;
	int beats_in    = 0;
	int hold_left   = 0;
	bit idle_on     = 1'b1;

	// texel memory mirror, face size and the queue of texels still to come back
	class texel_scoreboard;
		logic [cmtf_pkg::TEXEL_W-1:0] texel_mem [cmtf_pkg::NUM_FACES][FACE_TEXELS];
		bit                           texel_set [cmtf_pkg::NUM_FACES][FACE_TEXELS];
		int unsigned                  side_w;
		int unsigned                  side_h;
		cmtf_pkg::out_item_t          expected_texels [$];
		int                           errors;
		int                           lookups;
		int                           ties;
		int                           stores;

		function new();
			side_w  = cmtf_pkg::MAX_SIDE_DEF;
			side_h  = cmtf_pkg::MAX_SIDE_DEF;
			errors  = 0;
			lookups = 0;
			ties    = 0;
			stores  = 0;
		endfunction

		// zero reads as one, anything past the largest side saturates
		function void set_side(cmtf_pkg::cfg_reg_t r, logic [SW-1:0] value);
			int unsigned s;
			s = (value == '0) ? 1 : int'(value);
			if (s > cmtf_pkg::MAX_SIDE_DEF)
				s = cmtf_pkg::MAX_SIDE_DEF;
			if (r == cmtf_pkg::CFG_FACE_WIDTH)
				side_w = s;
			else
				side_h = s;
		endfunction

		// floor((minor + major) * (side - 1) / (2 * major))
		function int unsigned face_coord(int minor, int unsigned major, int unsigned side);
			longint num;
			num = longint'(minor) + longint'(major);
			return int'((num * (longint'(side) - 1)) / (2 * longint'(major)));
		endfunction

		// face and texel a direction points at; returns 1 when no axis wins outright
		function bit locate(cmtf_pkg::in_item_t it, output logic [FW-1:0] face,
				output int unsigned slot);
			int          x, y, z, u, v;
			int unsigned ax, ay, az, major;
			x = int'(it.dir_x);
			y = int'(it.dir_y);
			z = int'(it.dir_z);
			ax = (x < 0) ? -x : x;
			ay = (y < 0) ? -y : y;
			az = (z < 0) ? -z : z;
			face = cmtf_pkg::FACE_POS_X;
			slot = 0;
			if (ax > ay && ax > az) begin
				face = (x < 0) ? cmtf_pkg::FACE_NEG_X : cmtf_pkg::FACE_POS_X;
				major = ax;
				u = z;
				v = y;
			end else if (ay > ax && ay > az) begin
				face = (y < 0) ? cmtf_pkg::FACE_NEG_Y : cmtf_pkg::FACE_POS_Y;
				major = ay;
				u = x;
				v = z;
			end else if (az > ax && az > ay) begin
				face = (z < 0) ? cmtf_pkg::FACE_NEG_Z : cmtf_pkg::FACE_POS_Z;
				major = az;
				u = x;
				v = y;
			end else begin
				return 1'b1;
			end
			slot = face_coord(u, major, side_w) + face_coord(v, major, side_h) * side_w;
			return 1'b0;
		endfunction

		// apply one accepted beat: stores update the mirror, lookups queue a texel
		function void accept_item(cmtf_pkg::in_item_t it);
			logic [FW-1:0]       face;
			int unsigned         slot;
			cmtf_pkg::out_item_t texel;
			if (it.operation == cmtf_pkg::OP_STORE) begin
				stores++;
				if (it.face < cmtf_pkg::NUM_FACES && it.texel_index < FACE_TEXELS) begin
					texel_mem[it.face][it.texel_index] = it.texel_value;
					texel_set[it.face][it.texel_index] = 1'b1;
				end
			end else if (locate(it, face, slot)) begin
				texel.red      = cmtf_pkg::GRAY_LEVEL;
				texel.green    = cmtf_pkg::GRAY_LEVEL;
				texel.blue     = cmtf_pkg::GRAY_LEVEL;
				texel.alpha    = cmtf_pkg::OPAQUE_ALPHA;
				texel.tie_seen = 1'b1;
				texel.hit_face = cmtf_pkg::FACE_POS_X;
				ties++;
				expected_texels.push_back(texel);
			end else begin
				{texel.alpha, texel.blue, texel.green, texel.red} = texel_mem[face][slot];
				texel.tie_seen = 1'b0;
				texel.hit_face = face;
				expected_texels.push_back(texel);
			end
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		// check one returned texel against the oldest expectation
		function void check_texel(cmtf_pkg::out_item_t got);
			cmtf_pkg::out_item_t want;
			if (expected_texels.size() == 0) begin
				$error("texel beat with nothing expected: %h", got);
				errors++;
			end else begin
				want = expected_texels.pop_front();
				lookups++;
				compare("red", 32'(want.red), 32'(got.red));
				compare("green", 32'(want.green), 32'(got.green));
				compare("blue", 32'(want.blue), 32'(got.blue));
				compare("alpha", 32'(want.alpha), 32'(got.alpha));
				compare("tie_seen", 32'(want.tie_seen), 32'(got.tie_seen));
				compare("hit_face", 32'(want.hit_face), 32'(got.hit_face));
			end
		endfunction
	endclass

	texel_scoreboard sb;

	cube_map_direction_texel_fetch_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d texels outstanding",
				cycle_count, sb.expected_texels.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: long hold-off on request, otherwise random stalls while idling is on
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < 20);
			end
		end
	end

	// result monitor
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_texel(out_data);

	// every field random, operation forced
	function automatic cmtf_pkg::in_item_t random_item(cmtf_pkg::op_t op);
		cmtf_pkg::in_item_t it;
		it = {$urandom(), $urandom(), $urandom()};
		it.operation = op;
		return it;
	endfunction

	// offer one beat, random idle cycles ahead of it when idling is on, and wait for it to go in
	task automatic send(cmtf_pkg::in_item_t it);
		while (idle_on && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.accept_item(it);
		beats_in++;
	endtask

	task automatic store_texel(logic [FW-1:0] face, logic [cmtf_pkg::TIDX_W-1:0] idx,
			logic [cmtf_pkg::TEXEL_W-1:0] value);
		cmtf_pkg::in_item_t it;
		it = random_item(cmtf_pkg::OP_STORE);
		it.face        = face;
		it.texel_index = idx;
		it.texel_value = value;
		send(it);
	endtask

	// lookup, preceded by a store when the texel is unwritten or a fresh one is wanted
	task automatic look_up(logic signed [DW-1:0] x, logic signed [DW-1:0] y,
			logic signed [DW-1:0] z, bit refresh);
		cmtf_pkg::in_item_t it;
		logic [FW-1:0]      face;
		int unsigned        slot;
		it = random_item(cmtf_pkg::OP_LOOKUP);
		it.dir_x = x;
		it.dir_y = y;
		it.dir_z = z;
		if (!sb.locate(it, face, slot) && (refresh || !sb.texel_set[face][slot]))
			store_texel(face, slot[cmtf_pkg::TIDX_W-1:0], $urandom());
		send(it);
	endtask

	// directions: plain random, clear major axis, ties, extreme codes and tiny values
	task automatic random_direction(output logic signed [DW-1:0] x,
			output logic signed [DW-1:0] y, output logic signed [DW-1:0] z);
		int comp [3];
		int m;
		int axis;
		case ($urandom_range(9))
			0, 1: begin
				for (int i = 0; i < 3; i++)
					comp[i] = $urandom_range(65535) - 32768;
			end
			2, 3, 4, 5, 6: begin
				m = $urandom_range(32768, 1);
				for (int i = 0; i < 3; i++)
					comp[i] = $urandom_range(2 * m - 2, 0) - (m - 1);
				axis = $urandom_range(2);
				comp[axis] = $urandom_range(1) ? m : -m;
			end
			7: begin
				m = $urandom_range(32768, 0);
				for (int i = 0; i < 3; i++)
					comp[i] = $urandom_range(2 * m, 0) - m;
				axis = $urandom_range(2);
				comp[axis] = $urandom_range(1) ? m : -m;
				comp[(axis + 1) % 3] = $urandom_range(1) ? m : -m;
			end
			8: begin
				for (int i = 0; i < 3; i++)
					case ($urandom_range(5))
						0: comp[i] = -32768;
						1: comp[i] = -32767;
						2: comp[i] = -1;
						3: comp[i] = 0;
						4: comp[i] = 1;
						default: comp[i] = 32767;
					endcase
			end
			default: begin
				for (int i = 0; i < 3; i++)
					comp[i] = $urandom_range(6) - 3;
			end
		endcase
		// +32768 has no code, fold it onto the largest positive one
		for (int i = 0; i < 3; i++)
			if (comp[i] > 32767)
				comp[i] = 32767;
		x = DW'(comp[0]);
		y = DW'(comp[1]);
		z = DW'(comp[2]);
	endtask

	// mix of stray stores, store-then-lookup pairs and lookups of stored texels
	task automatic random_phase(int count);
		logic signed [DW-1:0] x, y, z;
		int                   target;
		target = beats_in + count;
		while (beats_in < target) begin
			random_direction(x, y, z);
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5: send(random_item(cmtf_pkg::OP_STORE));
				6, 7, 8:          look_up(x, y, z, 1'b1);
				default:          look_up(x, y, z, 1'b0);
			endcase
		end
	endtask

	// stop sending until every texel is back and the pipeline has emptied
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_texels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_face_size(logic [SW-1:0] w, logic [SW-1:0] h);
		cfg_write <= 1'b1;
		cfg_index <= cmtf_pkg::CFG_FACE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= cmtf_pkg::CFG_FACE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_side(cmtf_pkg::CFG_FACE_WIDTH, w);
		sb.set_side(cmtf_pkg::CFG_FACE_HEIGHT, h);
	endtask

	initial begin
		logic [SW-1:0] w, h;
		sb = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_write <= 1'b0;
		cfg_index <= cmtf_pkg::CFG_FACE_WIDTH;
		cfg_data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every face at its center, at reset size
		look_up(16'sd16384, 16'sd0, 16'sd0, 1'b0);
		look_up(-16'sd16384, 16'sd0, 16'sd0, 1'b0);
		look_up(16'sd0, 16'sd16384, 16'sd0, 1'b0);
		look_up(16'sd0, -16'sd16384, 16'sd0, 1'b0);
		look_up(16'sd0, 16'sd0, 16'sd16384, 1'b0);
		look_up(16'sd0, 16'sd0, -16'sd16384, 1'b0);
		// extreme codes and far corners
		look_up(16'sh8000, 16'sd32767, -16'sd32767, 1'b0);
		look_up(16'sd32767, -16'sd32766, 16'sd32766, 1'b0);
		look_up(16'sd3, -16'sd2, 16'sd2, 1'b0);
		// zero direction and ties between two or three axes
		look_up(16'sd0, 16'sd0, 16'sd0, 1'b0);
		look_up(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		look_up(16'sd100, -16'sd100, 16'sd7, 1'b0);
		look_up(16'sd5, -16'sd7, 16'sd7, 1'b0);
		// stores to the spare face codes are dropped, then first and last texels of real faces
		store_texel(FACE_SPARE_LO, 12'd0, 32'hdeadbeef);
		store_texel(FACE_SPARE_HI, 12'hfff, 32'h12345678);
		store_texel(cmtf_pkg::FACE_NEG_Z, 12'hfff, 32'hffffffff);
		store_texel(cmtf_pkg::FACE_POS_X, 12'h000, 32'h00000000);
		// fresh store immediately read back
		look_up(16'sd16384, -16'sd16383, -16'sd16383, 1'b1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < NUM_PHASES - 1) begin
				w = PHASE_W[p];
				h = PHASE_H[p];
			end else begin
				w = SW'($urandom_range(127));
				h = SW'($urandom_range(127));
			end
			settle();
			set_face_size(w, h);
			// two phases stream with no idling, the second of them starts with a long result hold-off
			idle_on = (p != 3);
			if (p == 4) begin
				idle_on   = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			random_phase(PHASE_ITEMS);
		end
		settle();

		$display("%0d beats in: %0d stores, %0d lookups checked (%0d ties)",
			beats_in, sb.stores, sb.lookups, sb.ties);
		$display("face sizes swept over %0d settings incl. register values 0, 1, 64, 127",
			NUM_PHASES + 1);
		if (sb.errors == 0 && sb.expected_texels.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
rtl/cmtf_pkg.sv
rtl/cmtf_ram.sv
rtl/cmtf_div.sv
rtl/cube_map_direction_texel_fetch_unit.sv
tb/testbench.sv
